### src/mexp_pkg.sv
// shared types for the modular exponentiation core
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

### src/mexp_mulmod.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module mexp_mulmod #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   x,
	input  logic [WIDTH-1:0]   y,
	input  logic [WIDTH:0]     m_ext,
	output logic [WIDTH-1:0]   result,
	output mexp_pkg::mm_stat_t stat
);
	import mexp_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0] dbl;
	logic [WIDTH:0] dbl_red;
	logic [WIDTH:0] sum;
	logic [WIDTH:0] sum_red;

	// double, reduce, add partial product, reduce
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		sum     = dbl_red + {1'b0, (y_q[WIDTH-1] ? x_q : {WIDTH{1'b0}})};
		sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			r_q <= sum_red[WIDTH-1:0];
			y_q <= {y_q[WIDTH-2:0], 1'b0};
		end
	end

	assign result    = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("multiplier done without a preceding busy cycle");

endmodule

### src/modular_exponentiation_core.sv
// modular exponentiation core: right-to-left square-and-multiply over a serial multiplier
// sequence: one base reduction, one multiply per set exponent bit, one squaring per bit below
// the top set bit, each a full pass of the serial multiplier; a zero exponent skips them all
// one item at a time: in_ready is high only while idle
// reset (arst_n low, asynchronous) clears the sequencer and handshakes and sets the modulus to 1
`timescale 1ns / 1ps

module modular_exponentiation_core #(
	parameter int WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mexp_pkg::DATA_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mexp_pkg::DATA_W-1:0]   base_value,
	input  logic [mexp_pkg::DATA_W-1:0]   exponent,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mexp_pkg::DATA_W-1:0]   power_mod
);
	import mexp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_MUL,
		ST_SQR,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] modulus_q;
	logic [WIDTH-1:0]  b_q;
	logic [WIDTH-1:0]  e_q;
	logic [WIDTH-1:0]  acc_q;
	logic [DATA_W-1:0] power_mod_q;
	logic              out_valid_q;
	logic              mm_start_q;
	logic [WIDTH-1:0]  mm_x_q;
	logic [WIDTH-1:0]  mm_y_q;

	logic [WIDTH-1:0]  mod_w;
	logic [WIDTH:0]    m_ext;
	logic [WIDTH-1:0]  base_w;
	logic [WIDTH-1:0]  exp_w;
	logic [WIDTH-1:0]  mm_res;
	mm_stat_t          mm_stat;

	// a zero modulus wraps at 2^WIDTH
	assign mod_w  = modulus_q[WIDTH-1:0];
	assign m_ext  = (mod_w == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_w};
	assign base_w = base_value[WIDTH-1:0];
	assign exp_w  = exponent[WIDTH-1:0];

	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start_q),
		.x      (mm_x_q),
		.y      (mm_y_q),
		.m_ext  (m_ext),
		.result (mm_res),
		.stat   (mm_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= DATA_W'(1);
			b_q         <= '0;
			e_q         <= '0;
			acc_q       <= '0;
			power_mod_q <= '0;
			out_valid_q <= 1'b0;
			mm_start_q  <= 1'b0;
			mm_x_q      <= '0;
			mm_y_q      <= '0;
		end else begin
			mm_start_q <= 1'b0;
			if (cfg_wr_en) begin
				modulus_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						acc_q <= WIDTH'(1);
						e_q   <= exp_w;
						if (exp_w == '0) begin
							state_q <= ST_FIN;
						end else begin
							mm_start_q <= 1'b1;
							mm_x_q     <= WIDTH'(1);
							mm_y_q     <= base_w;
							state_q    <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mm_stat.done) begin
						b_q        <= mm_res;
						mm_start_q <= 1'b1;
						mm_x_q     <= mm_res;
						if (e_q[0]) begin
							mm_y_q  <= acc_q;
							state_q <= ST_MUL;
						end else begin
							mm_y_q  <= mm_res;
							state_q <= ST_SQR;
						end
					end
				end
				ST_MUL: begin
					if (mm_stat.done) begin
						acc_q <= mm_res;
						if (e_q[WIDTH-1:1] != '0) begin
							mm_start_q <= 1'b1;
							mm_x_q     <= b_q;
							mm_y_q     <= b_q;
							state_q    <= ST_SQR;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SQR: begin
					if (mm_stat.done) begin
						b_q        <= mm_res;
						e_q        <= {1'b0, e_q[WIDTH-1:1]};
						mm_start_q <= 1'b1;
						mm_x_q     <= mm_res;
						if (e_q[1]) begin
							mm_y_q  <= acc_q;
							state_q <= ST_MUL;
						end else begin
							mm_y_q  <= mm_res;
							state_q <= ST_SQR;
						end
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						power_mod_q <= DATA_W'(acc_q);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign power_mod = power_mod_q;

	a_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mm_stat.done |-> (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier finished while the sequencer was not waiting");

	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start_q |-> !mm_stat.busy)
		else $error("multiplier started while busy");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		mm_stat.done |-> ({1'b0, mm_res} < m_ext))
		else $error("multiplier result not reduced");

	a_exponent_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQR && mm_stat.done) |-> (e_q[WIDTH-1:1] != '0))
		else $error("squaring beyond the top exponent bit");

endmodule
